// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the serial master.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tws_pkg.sv =====
// Package for the three-wire serial master: beat types, command codes,
// action codes and the command byte builder. No dependencies.
package tws_pkg;

   localparam int BURST_BYTES_DEFAULT = 8;

   localparam logic [1:0] ACT_SINGLE_WRITE = 2'd0;
   localparam logic [1:0] ACT_SINGLE_READ  = 2'd1;
   localparam logic [1:0] ACT_BURST_WRITE  = 2'd2;
   localparam logic [1:0] ACT_BURST_READ   = 2'd3;

   // action bit 0 selects read, bit 1 selects burst
   localparam int ACT_READ_BIT  = 0;
   localparam int ACT_BURST_BIT = 1;

   localparam logic [7:0] CMD_SINGLE_BASE = 8'h80;
   localparam logic [7:0] CMD_BURST_WRITE = 8'hBE;
   localparam logic [7:0] CMD_BURST_READ  = 8'hBF;

   typedef struct packed {
      logic       start_req;
      logic [1:0] action;
      logic [4:0] reg_addr;
      logic [7:0] write_byte;
      logic       io_in;
   } tws_req_type;

   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       io_out;
      logic       io_drive;
      logic       busy_res;
      logic       byte_taken;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       last_byte;
   } tws_rsp_type;

   // Build the command byte that opens a transaction.
   function automatic logic [7:0] make_command(input logic [1:0] action,
                                               input logic [4:0] reg_addr);
      logic [7:0] cmd;
      if (action[ACT_BURST_BIT]) begin
         cmd = action[ACT_READ_BIT] ? CMD_BURST_READ : CMD_BURST_WRITE;
      end else begin
         cmd = CMD_SINGLE_BASE | {2'b00, reg_addr, action[ACT_READ_BIT]};
      end
      return cmd;
   endfunction

endpackage

// ===== rtl/tws_engine.sv =====
// Transaction engine of the three-wire serial master: bit/byte state and
// the per-tick pin and status computation. Depends on tws_pkg.
module tws_engine #(
   parameter int BURST_BYTES = tws_pkg::BURST_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  tws_pkg::tws_req_type req,
   output tws_pkg::tws_rsp_type rsp
);
   import tws_pkg::*;

   localparam int CNT_W = $clog2(BURST_BYTES + 1);
   localparam logic [CNT_W:0] BURST_TOTAL = (CNT_W + 1)'(BURST_BYTES);
   localparam logic [CNT_W:0] SINGLE_TOTAL = (CNT_W + 1)'(1);

   logic             active_ff, active_in;
   logic [1:0]       mode_ff, mode_in;
   logic             data_stage_ff, data_stage_in;
   logic             phase_ff, phase_in;
   logic [2:0]       bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [7:0]       shift_ff, shift_in;
   logic [7:0]       accum_ff, accum_in;

   logic             start;
   logic             cur_active, cur_data_stage, cur_phase, reading, done;
   logic [1:0]       cur_mode;
   logic [2:0]       cur_bit;
   logic [CNT_W-1:0] cur_bytes;
   logic [7:0]       cur_shift, cur_accum;
   logic [CNT_W:0]   total, bytes_plus1, bytes_plus2;

   always_comb begin
      start          = !active_ff && req.start_req;
      cur_active     = active_ff || start;
      cur_mode       = start ? req.action : mode_ff;
      cur_data_stage = start ? 1'b0 : data_stage_ff;
      cur_phase      = start ? 1'b0 : phase_ff;
      cur_bit        = start ? 3'd0 : bit_cnt_ff;
      cur_bytes      = start ? '0 : byte_cnt_ff;
      cur_accum      = start ? 8'd0 : accum_ff;
      cur_shift      = start ? make_command(req.action, req.reg_addr) : shift_ff;

      reading     = cur_data_stage && cur_mode[ACT_READ_BIT];
      total       = cur_mode[ACT_BURST_BIT] ? BURST_TOTAL : SINGLE_TOTAL;
      bytes_plus1 = {1'b0, cur_bytes} + (CNT_W + 1)'(1);
      bytes_plus2 = {1'b0, cur_bytes} + (CNT_W + 1)'(2);
      done        = bytes_plus1 >= total;

      active_in     = cur_active;
      mode_in       = cur_mode;
      data_stage_in = cur_data_stage;
      phase_in      = cur_phase;
      bit_cnt_in    = cur_bit;
      byte_cnt_in   = cur_bytes;
      shift_in      = cur_shift;
      accum_in      = cur_accum;

      rsp              = '0;
      rsp.io_out       = 1'b1;

      if (cur_active) begin
         rsp.chip_enable  = 1'b1;
         rsp.busy_res     = 1'b1;
         rsp.serial_clock = cur_phase;
         if (reading) begin
            if (!cur_phase && req.io_in) begin
               accum_in = cur_accum | (8'd1 << cur_bit);
            end
         end else begin
            rsp.io_drive = 1'b1;
            rsp.io_out   = cur_shift[cur_bit];
         end

         if (!cur_phase) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            if (cur_bit != 3'd7) begin
               bit_cnt_in = cur_bit + 3'd1;
            end else begin
               bit_cnt_in = 3'd0;
               if (!cur_data_stage) begin
                  // command byte done: enter data stage, fetch first byte on writes
                  data_stage_in = 1'b1;
                  byte_cnt_in   = '0;
                  accum_in      = 8'd0;
                  if (!cur_mode[ACT_READ_BIT]) begin
                     shift_in       = req.write_byte;
                     rsp.byte_taken = 1'b1;
                     rsp.last_byte  = (total == SINGLE_TOTAL);
                  end
               end else begin
                  if (reading) begin
                     rsp.read_byte  = cur_accum;
                     rsp.read_valid = 1'b1;
                     rsp.last_byte  = done;
                     accum_in       = 8'd0;
                  end
                  byte_cnt_in = bytes_plus1[CNT_W-1:0];
                  if (done) begin
                     active_in     = 1'b0;
                     data_stage_in = 1'b0;
                     byte_cnt_in   = '0;
                  end else if (!reading) begin
                     shift_in       = req.write_byte;
                     rsp.byte_taken = 1'b1;
                     rsp.last_byte  = bytes_plus2 >= total;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         mode_ff       <= 2'd0;
         data_stage_ff <= 1'b0;
         phase_ff      <= 1'b0;
         bit_cnt_ff    <= 3'd0;
         byte_cnt_ff   <= '0;
         shift_ff      <= 8'd0;
         accum_ff      <= 8'd0;
      end else if (step) begin
         active_ff     <= active_in;
         mode_ff       <= mode_in;
         data_stage_ff <= data_stage_in;
         phase_ff      <= phase_in;
         bit_cnt_ff    <= bit_cnt_in;
         byte_cnt_ff   <= byte_cnt_in;
         shift_ff      <= shift_in;
         accum_ff      <= accum_in;
      end
   end

endmodule

// ===== rtl/three_wire_serial_master.sv =====
// Top level of the three-wire serial master: input beat register, engine
// and result register. Depends on tws_pkg and tws_engine.
//
// Each request beat is one tick, half a serial clock period; each tick
// returns exactly one response beat carrying the pin levels and status for
// that tick. A start request raises chip enable and shifts out the command
// byte (single access: address in bits 1..5 with bit 7 set and bit 0 set for
// reads; burst: 0xBE write, 0xBF read), then one data byte for a single
// access or BURST_BYTES bytes for a burst, all LSB first. The data bit is
// driven, or the line sampled on reads, in the low tick; the high tick
// follows. byte_taken marks the tick where write_byte is latched, read_valid
// the tick where a received byte is complete, last_byte the final data byte.
// Throughput is one tick per clock cycle while neither side stalls: the
// engine's state registers close the tick-to-tick loop. A request beat
// passes the input register, then the result register. Either side may
// stall; stalls only hold beats, they never drop or repeat a tick.
module three_wire_serial_master #(
   parameter int BURST_BYTES = tws_pkg::BURST_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tws_pkg::tws_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tws_pkg::tws_rsp_type rsp_data
);
   import tws_pkg::*;

   logic        in_valid_ff, in_valid_in;
   tws_req_type in_data_ff;
   logic        out_valid_ff, out_valid_in;
   tws_rsp_type out_data_ff;
   tws_rsp_type tick_rsp;
   logic        advance, req_accept;

   // advance the held tick whenever the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   tws_engine #(
      .BURST_BYTES(BURST_BYTES)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .step (advance),
      .req  (in_data_ff),
      .rsp  (tick_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on their beat, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= tick_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/tws_checker.sv =====
// Port-level checker for the three-wire serial master, bound to the top.
// Depends on tws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tws_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input tws_pkg::tws_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input tws_pkg::tws_rsp_type rsp_data
);
   import tws_pkg::*;

   logic rsp_idle, idle_ok;
   logic rsp_last, last_ok;
   logic rsp_reading, release_ok;
   logic rsp_both;

   assign rsp_idle = rsp_valid && !rsp_data.chip_enable;
   assign idle_ok  = !rsp_data.serial_clock && rsp_data.io_out && !rsp_data.io_drive
                     && !rsp_data.busy_res && !rsp_data.byte_taken
                     && !rsp_data.read_valid && !rsp_data.last_byte;

   assign rsp_last = rsp_valid && rsp_data.last_byte;
   assign last_ok  = (rsp_data.byte_taken || rsp_data.read_valid) && rsp_data.serial_clock;

   assign rsp_reading = rsp_valid && rsp_data.chip_enable && !rsp_data.io_drive;
   assign release_ok  = rsp_data.io_out
                        && (rsp_data.read_byte == 8'd0 || rsp_data.read_valid);

   assign rsp_both = rsp_data.byte_taken && rsp_data.read_valid;

   // idle tick shows released pins and no status
   `ASSERT_IMPLY(a_idle_pins, clock, reset, rsp_idle, idle_ok, "idle tick drives pins")
   // a tick never both latches a write byte and delivers a read byte
   `ASSERT_IMPLY(a_dir_excl, clock, reset, rsp_valid, !rsp_both, "byte_taken with read_valid")
   // last_byte only marks a byte event, and only in a high tick
   `ASSERT_IMPLY(a_last_evt, clock, reset, rsp_last, last_ok, "stray last_byte")
   // line released while reading
   `ASSERT_IMPLY(a_release, clock, reset, rsp_reading, release_ok, "line not released")
   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

endmodule

bind three_wire_serial_master tws_checker u_tws_checker (.*);
